// ===== design/rv64d_pkg.sv =====
// Shared opcodes, function codes, operation numbers, formats and control types for the decoder.
package rv64d_pkg;

  // Major opcodes (instruction bits 6..0)
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_OP32    = 7'h3B;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_OPIMM   = 7'h13;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_FP      = 7'h53;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;

  // funct7 / funct6 codes
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [5:0] F6_SRL    = 6'h00;
  localparam logic [5:0] F6_SRA    = 6'h10;

  // funct3 codes, integer ALU
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 codes, multiply/divide word ops
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_DIVU = 3'd5;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_REMU = 3'd7;

  // funct3 codes, memory access width
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_D  = 3'd3;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;
  localparam logic [2:0] F3_WU = 3'd6;

  // funct3 codes, branches
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Dense operation numbers
  localparam logic [5:0] OP_NONE   = 6'd0;
  localparam logic [5:0] OP_ADD    = 6'd1;
  localparam logic [5:0] OP_SUB    = 6'd9;
  localparam logic [5:0] OP_SRA    = 6'd10;
  localparam logic [5:0] OP_MUL    = 6'd11;
  localparam logic [5:0] OP_SLLW   = 6'd19;
  localparam logic [5:0] OP_SRLW   = 6'd20;
  localparam logic [5:0] OP_SRAW   = 6'd21;
  localparam logic [5:0] OP_MULW   = 6'd22;
  localparam logic [5:0] OP_DIVW   = 6'd23;
  localparam logic [5:0] OP_DIVUW  = 6'd24;
  localparam logic [5:0] OP_REMW   = 6'd25;
  localparam logic [5:0] OP_REMUW  = 6'd26;
  localparam logic [5:0] OP_LB     = 6'd27;
  localparam logic [5:0] OP_LH     = 6'd28;
  localparam logic [5:0] OP_LW     = 6'd29;
  localparam logic [5:0] OP_LBU    = 6'd30;
  localparam logic [5:0] OP_LHU    = 6'd31;
  localparam logic [5:0] OP_LWU    = 6'd32;
  localparam logic [5:0] OP_LD     = 6'd33;
  localparam logic [5:0] OP_ADDI   = 6'd34;
  localparam logic [5:0] OP_SLLI   = 6'd35;
  localparam logic [5:0] OP_SLTI   = 6'd36;
  localparam logic [5:0] OP_SLTIU  = 6'd37;
  localparam logic [5:0] OP_XORI   = 6'd38;
  localparam logic [5:0] OP_SRLI   = 6'd39;
  localparam logic [5:0] OP_SRAI   = 6'd40;
  localparam logic [5:0] OP_ORI    = 6'd41;
  localparam logic [5:0] OP_ANDI   = 6'd42;
  localparam logic [5:0] OP_JALR   = 6'd43;
  localparam logic [5:0] OP_FADD_S = 6'd44;
  localparam logic [5:0] OP_SLLIW  = 6'd45;
  localparam logic [5:0] OP_SRLIW  = 6'd46;
  localparam logic [5:0] OP_SRAIW  = 6'd47;
  localparam logic [5:0] OP_JAL    = 6'd48;
  localparam logic [5:0] OP_SB     = 6'd49;
  localparam logic [5:0] OP_SH     = 6'd50;
  localparam logic [5:0] OP_SW     = 6'd51;
  localparam logic [5:0] OP_SD     = 6'd52;
  localparam logic [5:0] OP_BEQ    = 6'd53;
  localparam logic [5:0] OP_BNE    = 6'd54;
  localparam logic [5:0] OP_BLT    = 6'd55;
  localparam logic [5:0] OP_BGE    = 6'd56;
  localparam logic [5:0] OP_BLTU   = 6'd57;
  localparam logic [5:0] OP_BGEU   = 6'd58;
  localparam logic [5:0] OP_LUI    = 6'd59;
  localparam logic [5:0] OP_AUIPC  = 6'd60;

  // Instruction formats
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_R    = 3'd1;
  localparam logic [2:0] FMT_I    = 3'd2;
  localparam logic [2:0] FMT_S    = 3'd3;
  localparam logic [2:0] FMT_B    = 3'd4;
  localparam logic [2:0] FMT_U    = 3'd5;
  localparam logic [2:0] FMT_J    = 3'd6;

  // Upper-immediate select codes
  localparam logic [1:0] UPPER_NONE  = 2'd0;
  localparam logic [1:0] UPPER_LUI   = 2'd1;
  localparam logic [1:0] UPPER_AUIPC = 2'd2;

  // Control bundle handed from the control generator to the result register
  typedef struct packed {
    logic       reg_write;
    logic       reg_read;
    logic       alu_use;
    logic       mem_write;
    logic       mem_read;
    logic       is_branch;
    logic [1:0] upper_select;
  } ctrl_t;

endpackage

// ===== design/rv64im_instruction_decoder_core.sv =====
// Top level of the RV64IM subset decoder: input register, decode logic, result register.
//
// Decodes one 32-bit RISC-V instruction word per transaction into an operation number
// (0 when unrecognized), its format, the raw rd/rs1/rs2 fields and the per-format
// control signals. The block is a two-register pipeline: an accepted word is captured
// in the input register, decoded by the opcode/funct matcher and control generator in
// the following cycle, and held in the result register until taken. One word is
// accepted every cycle while the downstream side keeps taking results; in_ready falls
// only when both registers are full and out_ready is low. There is no state beyond
// the pipeline and nothing to configure.
module rv64im_instruction_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  op_id,
  output logic [2:0]  format,
  output logic [4:0]  dest_reg,
  output logic [4:0]  src1_reg,
  output logic [4:0]  src2_reg,
  output logic        reg_write,
  output logic        reg_read,
  output logic        alu_use,
  output logic        mem_write,
  output logic        mem_read,
  output logic        is_branch,
  output logic [1:0]  upper_select
);

  logic              s1_valid;
  logic [31:0]       s1_instr;
  logic              s2_load;
  logic              s1_load;
  logic [5:0]        dec_op;
  logic [2:0]        dec_fmt;
  rv64d_pkg::ctrl_t  dec_ctrl;

  // Pipeline advance: result register frees when empty or taken
  assign s2_load  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_load;
  assign s1_load  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_instr <= instruction;
    end
  end

  // Decode logic
  rv64d_match u_match (
    .instr (s1_instr),
    .op    (dec_op)
  );

  rv64d_ctrl u_ctrl (
    .op   (dec_op),
    .fmt  (dec_fmt),
    .ctrl (dec_ctrl)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      op_id        <= dec_op;
      format       <= dec_fmt;
      dest_reg     <= s1_instr[11:7];
      src1_reg     <= s1_instr[19:15];
      src2_reg     <= s1_instr[24:20];
      reg_write    <= dec_ctrl.reg_write;
      reg_read     <= dec_ctrl.reg_read;
      alu_use      <= dec_ctrl.alu_use;
      mem_write    <= dec_ctrl.mem_write;
      mem_read     <= dec_ctrl.mem_read;
      is_branch    <= dec_ctrl.is_branch;
      upper_select <= dec_ctrl.upper_select;
    end
  end

  // Checks
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> s1_valid)
    else $error("accepted transaction not captured in input register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register is empty");

  a_unknown_all_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && op_id == rv64d_pkg::OP_NONE) |->
      (format == rv64d_pkg::FMT_NONE && !reg_write && !reg_read && !alu_use &&
       !mem_write && !mem_read && !is_branch && upper_select == rv64d_pkg::UPPER_NONE))
    else $error("unrecognized word produced active controls");

  a_mem_by_format: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!mem_write || format == rv64d_pkg::FMT_S) &&
                   (!mem_read || format == rv64d_pkg::FMT_I) &&
                   (!is_branch || format == rv64d_pkg::FMT_B)))
    else $error("memory or branch control outside its format");

  a_upper_only_u: assert property (@(posedge clk) disable iff (rst)
    (out_valid && upper_select != rv64d_pkg::UPPER_NONE) |->
      (format == rv64d_pkg::FMT_U && !reg_write && !alu_use))
    else $error("upper select set on a non-U operation");

endmodule

// ===== design/rv64d_match.sv =====
// Opcode/funct3/funct7 matcher that maps an instruction word to its dense operation number.
module rv64d_match (
  input  logic [31:0] instr,
  output logic [5:0]  op
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] f6;

  assign opc = instr[6:0];
  assign f3  = instr[14:12];
  assign f7  = instr[31:25];
  assign f6  = instr[31:26];

  // Match per major opcode; anything not listed decodes to OP_NONE
  always_comb begin
    op = rv64d_pkg::OP_NONE;
    case (opc)
      rv64d_pkg::OPC_OP: begin
        if (f7 == rv64d_pkg::F7_BASE) begin
          op = rv64d_pkg::OP_ADD + {3'b000, f3};
        end else if (f7 == rv64d_pkg::F7_ALT) begin
          if (f3 == rv64d_pkg::F3_ADD) op = rv64d_pkg::OP_SUB;
          else if (f3 == rv64d_pkg::F3_SR) op = rv64d_pkg::OP_SRA;
        end else if (f7 == rv64d_pkg::F7_MULDIV) begin
          op = rv64d_pkg::OP_MUL + {3'b000, f3};
        end
      end
      rv64d_pkg::OPC_OP32: begin
        if (f7 == rv64d_pkg::F7_BASE) begin
          if (f3 == rv64d_pkg::F3_SLL) op = rv64d_pkg::OP_SLLW;
          else if (f3 == rv64d_pkg::F3_SR) op = rv64d_pkg::OP_SRLW;
        end else if (f7 == rv64d_pkg::F7_ALT) begin
          if (f3 == rv64d_pkg::F3_SR) op = rv64d_pkg::OP_SRAW;
        end else if (f7 == rv64d_pkg::F7_MULDIV) begin
          case (f3)
            rv64d_pkg::F3_MUL:  op = rv64d_pkg::OP_MULW;
            rv64d_pkg::F3_DIV:  op = rv64d_pkg::OP_DIVW;
            rv64d_pkg::F3_DIVU: op = rv64d_pkg::OP_DIVUW;
            rv64d_pkg::F3_REM:  op = rv64d_pkg::OP_REMW;
            rv64d_pkg::F3_REMU: op = rv64d_pkg::OP_REMUW;
            default:            op = rv64d_pkg::OP_NONE;
          endcase
        end
      end
      rv64d_pkg::OPC_LOAD: begin
        case (f3)
          rv64d_pkg::F3_B:  op = rv64d_pkg::OP_LB;
          rv64d_pkg::F3_H:  op = rv64d_pkg::OP_LH;
          rv64d_pkg::F3_W:  op = rv64d_pkg::OP_LW;
          rv64d_pkg::F3_D:  op = rv64d_pkg::OP_LD;
          rv64d_pkg::F3_BU: op = rv64d_pkg::OP_LBU;
          rv64d_pkg::F3_HU: op = rv64d_pkg::OP_LHU;
          rv64d_pkg::F3_WU: op = rv64d_pkg::OP_LWU;
          default:          op = rv64d_pkg::OP_NONE;
        endcase
      end
      rv64d_pkg::OPC_OPIMM: begin
        // 64-bit shift immediates check funct6 only; bit 25 is shamt[5]
        case (f3)
          rv64d_pkg::F3_ADD:  op = rv64d_pkg::OP_ADDI;
          rv64d_pkg::F3_SLL:  op = (f6 == rv64d_pkg::F6_SRL) ? rv64d_pkg::OP_SLLI
                                                            : rv64d_pkg::OP_NONE;
          rv64d_pkg::F3_SLT:  op = rv64d_pkg::OP_SLTI;
          rv64d_pkg::F3_SLTU: op = rv64d_pkg::OP_SLTIU;
          rv64d_pkg::F3_XOR:  op = rv64d_pkg::OP_XORI;
          rv64d_pkg::F3_SR: begin
            if (f6 == rv64d_pkg::F6_SRL) op = rv64d_pkg::OP_SRLI;
            else if (f6 == rv64d_pkg::F6_SRA) op = rv64d_pkg::OP_SRAI;
          end
          rv64d_pkg::F3_OR:   op = rv64d_pkg::OP_ORI;
          default:            op = rv64d_pkg::OP_ANDI;
        endcase
      end
      rv64d_pkg::OPC_JALR: begin
        if (f3 == rv64d_pkg::F3_ADD) op = rv64d_pkg::OP_JALR;
      end
      rv64d_pkg::OPC_FP: begin
        // funct3 is the rounding mode here, any value accepted
        if (f7 == rv64d_pkg::F7_BASE) op = rv64d_pkg::OP_FADD_S;
      end
      rv64d_pkg::OPC_OPIMM32: begin
        if (f7 == rv64d_pkg::F7_BASE) begin
          if (f3 == rv64d_pkg::F3_SLL) op = rv64d_pkg::OP_SLLIW;
          else if (f3 == rv64d_pkg::F3_SR) op = rv64d_pkg::OP_SRLIW;
        end else if (f7 == rv64d_pkg::F7_ALT) begin
          if (f3 == rv64d_pkg::F3_SR) op = rv64d_pkg::OP_SRAIW;
        end
      end
      rv64d_pkg::OPC_JAL: op = rv64d_pkg::OP_JAL;
      rv64d_pkg::OPC_STORE: begin
        case (f3)
          rv64d_pkg::F3_B: op = rv64d_pkg::OP_SB;
          rv64d_pkg::F3_H: op = rv64d_pkg::OP_SH;
          rv64d_pkg::F3_W: op = rv64d_pkg::OP_SW;
          rv64d_pkg::F3_D: op = rv64d_pkg::OP_SD;
          default:         op = rv64d_pkg::OP_NONE;
        endcase
      end
      rv64d_pkg::OPC_BRANCH: begin
        case (f3)
          rv64d_pkg::F3_BEQ:  op = rv64d_pkg::OP_BEQ;
          rv64d_pkg::F3_BNE:  op = rv64d_pkg::OP_BNE;
          rv64d_pkg::F3_BLT:  op = rv64d_pkg::OP_BLT;
          rv64d_pkg::F3_BGE:  op = rv64d_pkg::OP_BGE;
          rv64d_pkg::F3_BLTU: op = rv64d_pkg::OP_BLTU;
          rv64d_pkg::F3_BGEU: op = rv64d_pkg::OP_BGEU;
          default:            op = rv64d_pkg::OP_NONE;
        endcase
      end
      rv64d_pkg::OPC_LUI:   op = rv64d_pkg::OP_LUI;
      rv64d_pkg::OPC_AUIPC: op = rv64d_pkg::OP_AUIPC;
      default:              op = rv64d_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== design/rv64d_ctrl.sv =====
// Format classifier and control-signal generator driven by the operation number.
module rv64d_ctrl (
  input  logic [5:0]       op,
  output logic [2:0]       fmt,
  output rv64d_pkg::ctrl_t ctrl
);

  // Operation numbers are grouped by format, so ranges pick the format
  always_comb begin
    if (op == rv64d_pkg::OP_NONE) begin
      fmt = rv64d_pkg::FMT_NONE;
    end else if (op <= rv64d_pkg::OP_REMUW || op == rv64d_pkg::OP_FADD_S) begin
      fmt = rv64d_pkg::FMT_R;
    end else if (op <= rv64d_pkg::OP_SRAIW) begin
      fmt = rv64d_pkg::FMT_I;
    end else if (op == rv64d_pkg::OP_JAL) begin
      fmt = rv64d_pkg::FMT_J;
    end else if (op <= rv64d_pkg::OP_SD) begin
      fmt = rv64d_pkg::FMT_S;
    end else if (op <= rv64d_pkg::OP_BGEU) begin
      fmt = rv64d_pkg::FMT_B;
    end else begin
      fmt = rv64d_pkg::FMT_U;
    end
  end

  // Per-format control outputs; unknown format leaves everything off
  always_comb begin
    ctrl = '0;
    case (fmt)
      rv64d_pkg::FMT_R: begin
        ctrl.reg_write = 1'b1;
        ctrl.reg_read  = 1'b1;
        ctrl.alu_use   = 1'b1;
      end
      rv64d_pkg::FMT_I: begin
        ctrl.reg_write = 1'b1;
        ctrl.reg_read  = 1'b1;
        ctrl.alu_use   = 1'b1;
        ctrl.mem_read  = (op >= rv64d_pkg::OP_LB) && (op <= rv64d_pkg::OP_LD);
      end
      rv64d_pkg::FMT_S: begin
        ctrl.reg_read  = 1'b1;
        ctrl.alu_use   = 1'b1;
        ctrl.mem_write = 1'b1;
      end
      rv64d_pkg::FMT_B: begin
        ctrl.reg_read  = 1'b1;
        ctrl.alu_use   = 1'b1;
        ctrl.is_branch = 1'b1;
      end
      rv64d_pkg::FMT_U: begin
        ctrl.reg_read     = 1'b1;
        ctrl.upper_select = (op == rv64d_pkg::OP_LUI) ? rv64d_pkg::UPPER_LUI
                                                      : rv64d_pkg::UPPER_AUIPC;
      end
      rv64d_pkg::FMT_J: begin
        ctrl.reg_write = 1'b1;
        ctrl.alu_use   = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

endmodule
